FILE: rtl/core/sha256_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_pkg: shared types and constants of the SHA-256 byte hasher
// Controller states, command and status bundles, round constants and
// initial hash values.
// ----------------------------------------------------------------------------
package sha256_pkg;

	// controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_PAD,
		S_COMP,
		S_ADD,
		S_OUT
	} ctrl_state_t;

	// source of the byte shifted into the block window
	typedef enum logic [1:0] {
		SEL_IN,
		SEL_80,
		SEL_ZERO,
		SEL_LEN
	} byte_sel_t;

	// controller -> datapath
	typedef struct packed {
		logic      shift_en;
		byte_sel_t byte_sel;
		logic      load_work;
		logic      round_en;
		logic      add_chain;
		logic      out_adv;
		logic      restart;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic fill_last;
		logic fill_ge56;
		logic round_last;
		logic out_last;
	} dp_sts_t;

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_POS  = 6'd56;

	localparam logic [31:0] INIT_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

endpackage
`default_nettype wire

FILE: rtl/core/sha256_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_if: input and output channels of the SHA-256 byte hasher
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface sha256_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_present;
	logic       end_of_message;

	modport source (output valid, data_byte, byte_present, end_of_message, input ready);
	modport sink   (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface sha256_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic        last_word;

	modport source (output valid, digest_word, last_word, input ready);
	modport sink   (input valid, digest_word, last_word, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/sha256_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_ctrl: sequencing of the SHA-256 byte hasher
// Accepts bytes, runs compression, steps through padding and digest output.
// ----------------------------------------------------------------------------
module sha256_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire logic                in_present,
	input  wire logic                in_end,
	output logic                     in_ready,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output sha256_pkg::dp_cmd_t      cmd,
	input  wire sha256_pkg::dp_sts_t sts
);

	sha256_pkg::ctrl_state_t state_q, state_d;
	logic end_pend_q;   // message closed by the byte that filled the block
	logic pad_act_q;    // compression was started from padding
	logic first_pad_q;  // next pad byte is the 0x80 marker
	logic lenblk_q;     // current block carries the bit length

	logic take_byte;
	assign take_byte = in_valid & in_present;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sha256_pkg::S_IDLE: begin
				if (take_byte && sts.fill_last) begin
					state_d = sha256_pkg::S_COMP;
				end else if (in_valid && in_end) begin
					state_d = sha256_pkg::S_PAD;
				end
			end
			sha256_pkg::S_PAD: begin
				if (sts.fill_last) begin
					state_d = sha256_pkg::S_COMP;
				end
			end
			sha256_pkg::S_COMP: begin
				if (sts.round_last) begin
					state_d = sha256_pkg::S_ADD;
				end
			end
			sha256_pkg::S_ADD: begin
				if (pad_act_q) begin
					state_d = lenblk_q ? sha256_pkg::S_OUT : sha256_pkg::S_PAD;
				end else begin
					state_d = end_pend_q ? sha256_pkg::S_PAD : sha256_pkg::S_IDLE;
				end
			end
			sha256_pkg::S_OUT: begin
				if (out_ready && sts.out_last) begin
					state_d = sha256_pkg::S_IDLE;
				end
			end
			default: state_d = sha256_pkg::S_IDLE;
		endcase
	end

	// outputs and datapath commands
	always_comb begin
		in_ready      = 1'b0;
		out_valid     = 1'b0;
		cmd           = '0;
		cmd.byte_sel  = sha256_pkg::SEL_IN;
		unique case (state_q)
			sha256_pkg::S_IDLE: begin
				in_ready      = 1'b1;
				cmd.shift_en  = take_byte;
				cmd.load_work = take_byte & sts.fill_last;
			end
			sha256_pkg::S_PAD: begin
				cmd.shift_en  = 1'b1;
				cmd.load_work = sts.fill_last;
				if (first_pad_q) begin
					cmd.byte_sel = sha256_pkg::SEL_80;
				end else if (sts.fill_ge56 && lenblk_q) begin
					cmd.byte_sel = sha256_pkg::SEL_LEN;
				end else begin
					cmd.byte_sel = sha256_pkg::SEL_ZERO;
				end
			end
			sha256_pkg::S_COMP: begin
				cmd.round_en = 1'b1;
			end
			sha256_pkg::S_ADD: begin
				cmd.add_chain = 1'b1;
			end
			sha256_pkg::S_OUT: begin
				out_valid    = 1'b1;
				cmd.out_adv  = out_ready;
				cmd.restart  = out_ready & sts.out_last;
			end
			default: ;
		endcase
	end

	// state and padding flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sha256_pkg::S_IDLE;
			end_pend_q  <= 1'b0;
			pad_act_q   <= 1'b0;
			first_pad_q <= 1'b1;
			lenblk_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				sha256_pkg::S_IDLE: begin
					end_pend_q  <= in_end;
					pad_act_q   <= 1'b0;
					first_pad_q <= 1'b1;
					lenblk_q    <= 1'b0;
				end
				sha256_pkg::S_PAD: begin
					pad_act_q   <= 1'b1;
					first_pad_q <= 1'b0;
					// marker below byte 56 leaves room for the length here
					if (first_pad_q && !sts.fill_ge56) begin
						lenblk_q <= 1'b1;
					end
				end
				sha256_pkg::S_ADD: begin
					if (pad_act_q) begin
						lenblk_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/sha256_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_dp: datapath of the SHA-256 byte hasher
// Block window with in-place message schedule, one-round compression unit,
// chaining words, byte and length counters, digest word select.
// ----------------------------------------------------------------------------
module sha256_dp (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire sha256_pkg::dp_cmd_t cmd,
	output sha256_pkg::dp_sts_t      sts,
	input  wire logic [7:0]          data_byte,
	output logic [31:0]              digest_word,
	output logic                     last_word
);

	logic [31:0] w_q   [16];   // block window, w_q[0] is the oldest word
	logic [31:0] r_q   [8];    // working variables a..h
	logic [31:0] h_q   [8];    // chaining words
	logic [5:0]  fill_q;
	logic [60:0] len_q;
	logic [5:0]  rnd_q;
	logic [2:0]  oidx_q;

	function automatic logic [31:0] ror32(input logic [31:0] v, input int n);
		return (v >> n) | (v << (32 - n));
	endfunction

	// byte to shift in
	logic [63:0] len_bits;
	logic [63:0] len_shift;
	logic [7:0]  byte_w;

	assign len_bits  = {len_q, 3'b000};
	assign len_shift = len_bits >> {~fill_q[2:0], 3'b000};

	always_comb begin
		unique case (cmd.byte_sel)
			sha256_pkg::SEL_IN:   byte_w = data_byte;
			sha256_pkg::SEL_80:   byte_w = sha256_pkg::PAD_BYTE;
			sha256_pkg::SEL_ZERO: byte_w = 8'h00;
			sha256_pkg::SEL_LEN:  byte_w = len_shift[7:0];
			default:              byte_w = 8'h00;
		endcase
	end

	// schedule expansion from the window
	logic [31:0] sig0, sig1, w_new;
	assign sig0  = ror32(w_q[1], 7) ^ ror32(w_q[1], 18) ^ (w_q[1] >> 3);
	assign sig1  = ror32(w_q[14], 17) ^ ror32(w_q[14], 19) ^ (w_q[14] >> 10);
	assign w_new = w_q[0] + sig0 + w_q[9] + sig1;

	// one compression round
	logic [31:0] big1, choose, x1, big0, major, x2;
	assign big1   = ror32(r_q[4], 6) ^ ror32(r_q[4], 11) ^ ror32(r_q[4], 25);
	assign choose = (r_q[4] & r_q[5]) ^ (~r_q[4] & r_q[6]);
	assign x1     = r_q[7] + big1 + choose + sha256_pkg::ROUND_K[rnd_q] + w_q[0];
	assign big0   = ror32(r_q[0], 2) ^ ror32(r_q[0], 13) ^ ror32(r_q[0], 22);
	assign major  = (r_q[0] & r_q[1]) ^ (r_q[0] & r_q[2]) ^ (r_q[1] & r_q[2]);
	assign x2     = big0 + major;

	// block window: byte shift or schedule rotation
	always_ff @(posedge clk) begin
		if (cmd.shift_en) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= {w_q[i][23:0], w_q[i+1][31:24]};
			end
			w_q[15] <= {w_q[15][23:0], byte_w};
		end else if (cmd.round_en) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= w_new;
		end
	end

	// working variables
	always_ff @(posedge clk) begin
		if (cmd.load_work) begin
			for (int j = 0; j < 8; j++) begin
				r_q[j] <= h_q[j];
			end
		end else if (cmd.round_en) begin
			r_q[7] <= r_q[6];
			r_q[6] <= r_q[5];
			r_q[5] <= r_q[4];
			r_q[4] <= r_q[3] + x1;
			r_q[3] <= r_q[2];
			r_q[2] <= r_q[1];
			r_q[1] <= r_q[0];
			r_q[0] <= x1 + x2;
		end
	end

	// chaining words, counters and output index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < 8; j++) begin
				h_q[j] <= sha256_pkg::INIT_H[j];
			end
			fill_q <= '0;
			len_q  <= '0;
			rnd_q  <= '0;
			oidx_q <= '0;
		end else begin
			if (cmd.restart) begin
				for (int j = 0; j < 8; j++) begin
					h_q[j] <= sha256_pkg::INIT_H[j];
				end
			end else if (cmd.add_chain) begin
				for (int j = 0; j < 8; j++) begin
					h_q[j] <= h_q[j] + r_q[j];
				end
			end
			if (cmd.shift_en) begin
				fill_q <= fill_q + 6'd1;
			end
			if (cmd.restart) begin
				len_q <= '0;
			end else if (cmd.shift_en && cmd.byte_sel == sha256_pkg::SEL_IN) begin
				len_q <= len_q + 61'd1;
			end
			if (cmd.load_work) begin
				rnd_q <= '0;
			end else if (cmd.round_en) begin
				rnd_q <= rnd_q + 6'd1;
			end
			if (cmd.out_adv) begin
				oidx_q <= oidx_q + 3'd1;
			end
		end
	end

	assign digest_word    = h_q[oidx_q];
	assign last_word      = (oidx_q == 3'd7);

	assign sts.fill_last  = (fill_q == 6'd63);
	assign sts.fill_ge56  = (fill_q >= sha256_pkg::LEN_POS);
	assign sts.round_last = (rnd_q == 6'd63);
	assign sts.out_last   = (oidx_q == 3'd7);

endmodule
`default_nettype wire

FILE: rtl/core/sha256_byte_hasher.sv
`default_nettype none
// Flow: bytes are taken while idle; the byte that completes a 64-byte block
//   starts the rounds of the one-round compressor and the chaining add.
// End of message: pad bytes fill up to the end of the block (one more
//   block when fewer than 9 bytes remain), each block is compressed, then
//   8 digest words, one per cycle while the sink is ready.
// Reset clears control, counters and restores the initial hash values.
// ----------------------------------------------------------------------------
// sha256_byte_hasher: SHA-256 over a byte stream
// Hashes incoming bytes, pads on end of message and emits the 8-word digest.
// ----------------------------------------------------------------------------
module sha256_byte_hasher (
	input  wire logic     clk,
	input  wire logic     arst_n,
	sha256_in_if.sink     in_ch,
	sha256_out_if.source  out_ch
);

	sha256_pkg::dp_cmd_t cmd;
	sha256_pkg::dp_sts_t sts;

	sha256_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_ch.valid),
		.in_present (in_ch.byte_present),
		.in_end     (in_ch.end_of_message),
		.in_ready   (in_ch.ready),
		.out_valid  (out_ch.valid),
		.out_ready  (out_ch.ready),
		.cmd        (cmd),
		.sts        (sts)
	);

	sha256_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.data_byte   (in_ch.data_byte),
		.digest_word (out_ch.digest_word),
		.last_word   (out_ch.last_word)
	);

endmodule
`default_nettype wire

FILE: rtl/core/sha256_chk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_chk: port-level checks of the SHA-256 byte hasher
// Watches the channel handshakes and the digest word sequence.
// ----------------------------------------------------------------------------
module sha256_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [31:0] digest_word,
	input wire logic        last_word
);

	// a pending digest word holds until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(digest_word))
		else $error("digest word dropped or changed while stalled");

	// no new input while a digest is being delivered
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input accepted during digest output");

	// digest words come back to back until the last one
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_word |=> out_valid && !in_ready)
		else $error("digest burst broken before last word");

	// the last word closes the digest and the block returns to input
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last_word |=> !out_valid && in_ready)
		else $error("digest output continued after last word");

endmodule

bind sha256_byte_hasher sha256_chk u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (in_ch.ready),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.digest_word (out_ch.digest_word),
	.last_word   (out_ch.last_word)
);
`default_nettype wire
